// ----- rtl/core/mdtt_pkg.sv -----
// Shared types and constants for the multichannel duty toggle timer.
// No dependencies; imported by every module of the core.
`timescale 1ns / 1ps
`default_nettype none

package mdtt_pkg;

    localparam int CHANNELS  = 16;
    localparam int TIME_BITS = 16;
    localparam int CH_BITS   = 4;     // channel field width
    localparam int TL_BITS   = 8;     // tick_limit width
    localparam int SPM_BITS  = 6;     // seconds_per_minute width
    localparam int CFG_IDX_BITS = 1;

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
    localparam logic [TIME_BITS-1:0] TIME_ZERO = '0;

    localparam logic [TL_BITS-1:0]  TICK_LIMIT_RST = 8'd61;
    localparam logic [SPM_BITS-1:0] SPM_RST        = 6'd60;

    localparam logic [CFG_IDX_BITS-1:0] CFG_TICK_LIMIT  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SEC_PER_MIN = 1'b1;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_DUTY  = 2'd1,
        MODE_FORCE = 2'd2
    } mode_t;

    // Command broadcast to every channel for one processed word
    typedef struct packed {
        logic                 step;        // minute step
        logic                 reload;      // write taken: reload all countdowns
        logic                 force_en;    // write forces the level
        logic                 force_level;
        logic [TIME_BITS-1:0] wr_high;
        logic [TIME_BITS-1:0] wr_low;
    } chan_cmd_t;

endpackage : mdtt_pkg

`default_nettype wire

// ----- rtl/core/multichannel_duty_toggle_timer_core.sv -----
// Path: an accepted word goes into the input register, then through the channel
// update into the result register, from which the result word can be taken; all
// channels update in parallel.
// Throughput: one word per cycle; m_tready low holds the result word and stalls the
// input once the input register is also full.
// Reset (aresetn low, synchronous): counters cleared, levels low, all stored
// times and countdowns at their maximum, registers at their defaults.
`timescale 1ns / 1ps
`default_nettype none

module multichannel_duty_toggle_timer_core
    import mdtt_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    // configuration write port
    input  wire logic                    cfg_wr_en,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_wr_index,
    input  wire logic [TL_BITS-1:0]      cfg_wr_data,
    // input stream
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [39:0]             s_tdata,  // channel, level, high_time, low_time
    input  wire logic [1:0]              s_tuser,  // mode
    // result stream
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [23:0]                  m_tdata   // levels, minute_strobe
);

    logic [TL_BITS-1:0]  tick_limit_reg;
    logic [SPM_BITS-1:0] spm_reg;

    logic                 in_valid_reg;
    logic [1:0]           in_mode_reg;
    logic [CH_BITS-1:0]   in_ch_reg;
    logic                 in_level_reg;
    logic [TIME_BITS-1:0] in_high_reg;
    logic [TIME_BITS-1:0] in_low_reg;

    logic [TL_BITS-1:0]  tick_count_reg, tick_count_next;
    logic [SPM_BITS-1:0] sec_count_reg, sec_count_next;

    logic                out_valid_reg;
    logic [CHANNELS-1:0] out_levels_reg;
    logic                out_strobe_reg;

    logic                advance;
    logic                strobe;
    logic                ch_ok;
    logic [SPM_BITS:0]   sec_plus;
    chan_cmd_t           cmd;
    logic [CHANNELS-1:0] levels_next;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign ch_ok    = {1'b0, in_ch_reg} < (CH_BITS+1)'(CHANNELS);
    assign sec_plus = {1'b0, sec_count_reg} + (SPM_BITS+1)'(1);

    always_comb begin
        tick_count_next = tick_count_reg;
        sec_count_next  = sec_count_reg;
        strobe          = 1'b0;
        cmd             = '0;
        unique case (in_mode_reg)
            MODE_TICK: begin
                if (tick_count_reg >= tick_limit_reg) begin
                    tick_count_next = '0;
                    if (sec_plus >= {1'b0, spm_reg}) begin
                        sec_count_next = '0;
                        strobe         = 1'b1;
                    end else begin
                        sec_count_next = sec_plus[SPM_BITS-1:0];
                    end
                end else begin
                    tick_count_next = tick_count_reg + TL_BITS'(1);
                end
            end
            MODE_DUTY: begin
                cmd.reload  = ch_ok;
                cmd.wr_high = in_high_reg;
                cmd.wr_low  = in_low_reg;
            end
            MODE_FORCE: begin
                cmd.reload      = ch_ok;
                cmd.force_en    = 1'b1;
                cmd.force_level = in_level_reg;
                cmd.wr_high     = in_level_reg ? TIME_MAX : TIME_ZERO;
                cmd.wr_low      = in_level_reg ? TIME_ZERO : TIME_MAX;
            end
            default: begin
            end
        endcase
        cmd.step = strobe;
    end

    for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
        mdtt_chan u_chan (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .advance    (advance),
            .sel        (in_ch_reg == CH_BITS'(i)),
            .cmd        (cmd),
            .level_next (levels_next[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_limit_reg <= TICK_LIMIT_RST;
            spm_reg        <= SPM_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_TICK_LIMIT:  tick_limit_reg <= cfg_wr_data;
                CFG_SEC_PER_MIN: spm_reg        <= cfg_wr_data[SPM_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_mode_reg  <= s_tuser;
            in_ch_reg    <= s_tdata[3:0];
            in_level_reg <= s_tdata[4];
            in_high_reg  <= s_tdata[20:5];
            in_low_reg   <= s_tdata[36:21];
        end
    end

    // prescaler and seconds divider, result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg <= '0;
            sec_count_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (advance) begin
                tick_count_reg <= tick_count_next;
                sec_count_reg  <= sec_count_next;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_levels_reg <= levels_next;
            out_strobe_reg <= strobe;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_strobe_reg, out_levels_reg};

endmodule : multichannel_duty_toggle_timer_core

`default_nettype wire

// ----- rtl/core/mdtt_chan.sv -----
// One timer channel: stored high/low times, minute countdown and level bit.
// Depends on mdtt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mdtt_chan
    import mdtt_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      advance,
    input  wire logic      sel,
    input  wire chan_cmd_t cmd,
    output logic           level_next
);

    logic [TIME_BITS-1:0] high_reg, high_next;
    logic [TIME_BITS-1:0] low_reg, low_next;
    logic [TIME_BITS-1:0] cd_reg, cd_next;
    logic                 level_reg;

    always_comb begin
        high_next  = high_reg;
        low_next   = low_reg;
        cd_next    = cd_reg;
        level_next = level_reg;
        if (cmd.reload) begin
            if (sel) begin
                high_next = cmd.wr_high;
                low_next  = cmd.wr_low;
                if (cmd.force_en) begin
                    level_next = cmd.force_level;
                end
            end
            cd_next = level_next ? high_next : low_next;
        end else if (cmd.step) begin
            if (cd_reg != TIME_ZERO) begin
                cd_next = cd_reg - TIME_BITS'(1);
            end else begin
                // phase over: enter the opposite phase
                cd_next    = level_reg ? low_reg : high_reg;
                level_next = ~level_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_reg  <= TIME_MAX;
            low_reg   <= TIME_MAX;
            cd_reg    <= TIME_MAX;
            level_reg <= 1'b0;
        end else if (advance) begin
            high_reg  <= high_next;
            low_reg   <= low_next;
            cd_reg    <= cd_next;
            level_reg <= level_next;
        end
    end

endmodule : mdtt_chan

`default_nettype wire

// ----- rtl/core/mdtt_checker.sv -----
// Port-level checks for the timer core, attached to the top level by bind.
// Depends on mdtt_pkg and multichannel_duty_toggle_timer_core.
`timescale 1ns / 1ps
`default_nettype none

module mdtt_checker
    import mdtt_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);

    // a result slot being drained always frees the input side
    a_ready_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("s_tready low while m_tready high");

    // a fresh result follows its input word through the input and result registers
    a_result_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result word without matching input word");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

endmodule : mdtt_checker

bind multichannel_duty_toggle_timer_core mdtt_checker u_mdtt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
